[src/hpp_pkg.sv]
package hpp_pkg;

	localparam int CHAR_W = 8;
	localparam int PORT_W = 16;
	localparam int LEN_W = 6;
	localparam int ACC_W = 17;
	localparam int PROD_W = 20;
	localparam int ADDR_CAP_DEF = 64;
	localparam int CFG_AW = 2;
	localparam int CFG_DW = 32;

	localparam logic [ACC_W-1:0] PORT_LIMIT = 17'd65535;

	localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
	localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
	localparam logic [CHAR_W-1:0] CH_OPEN = 8'h5B;
	localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h5D;
	localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR = 8'h0D;

	localparam logic [1:0] PH_NONE = 2'd0;
	localparam logic [1:0] PH_COLON = 2'd1;
	localparam logic [1:0] PH_OTHER = 2'd2;

	localparam logic [CFG_AW-1:0] REG_DEFAULT_PORT = 2'd0;

	typedef struct packed {
		logic accepted;
		logic address_start;
		logic [LEN_W-1:0] address_length;
		logic [PORT_W-1:0] port_number;
	} verdict_t;

	function automatic logic is_space(input logic [CHAR_W-1:0] c);
		is_space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

endpackage

[src/hpp_if.sv]
interface hpp_char_if;
	logic valid;
	logic ready;
	logic [hpp_pkg::CHAR_W-1:0] character;
	logic last_char;

	modport source(output valid, output character, output last_char, input ready);
	modport sink(input valid, input character, input last_char, output ready);
endinterface

interface hpp_verdict_if;
	logic valid;
	logic ready;
	logic accepted;
	logic address_start;
	logic [hpp_pkg::LEN_W-1:0] address_length;
	logic [hpp_pkg::PORT_W-1:0] port_number;

	modport source(output valid, output accepted, output address_start,
		output address_length, output port_number, input ready);
	modport sink(input valid, input accepted, input address_start,
		input address_length, input port_number, output ready);
endinterface

[src/host_port_string_parser.sv]
// Host and port string parser.
// The chars channel carries one byte of a host string per word, with
// last_char set on the final byte. Every string yields exactly one word
// on the verdict channel: accepted, address_start, address_length and
// port_number. Bytes other than the last one produce nothing.
// A word accepted on chars is registered in the input register and
// evaluated there against the running string state; the verdict of a
// final byte is then registered in the verdict register, which drives
// verdict.valid. The block takes one byte per cycle unless a final byte
// waits for the verdict register, limited only by the single parse stage.
// When verdict is stalled, the block keeps taking bytes of the next
// string; only a final byte waits in the input register until the
// verdict register is free, and chars.ready then drops.
// default_port is written over the APB port at byte address 0.
// Reset clears default_port, the string state and both valid flags.
module host_port_string_parser #(
	parameter int ADDR_CAP = hpp_pkg::ADDR_CAP_DEF
) (
	input logic clk,
	input logic arst_n,
	hpp_char_if.sink chars,
	hpp_verdict_if.source verdict,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [hpp_pkg::CFG_AW-1:0] paddr,
	input logic [hpp_pkg::CFG_DW-1:0] pwdata,
	output logic [hpp_pkg::CFG_DW-1:0] prdata,
	output logic pready
);

	logic [hpp_pkg::PORT_W-1:0] default_port;
	logic res_free;
	logic res_load;
	hpp_pkg::verdict_t res;
	hpp_pkg::verdict_t res_q;
	logic res_valid_q;

	hpp_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.default_port(default_port)
	);

	hpp_parse #(
		.ADDR_CAP(ADDR_CAP)
	) u_parse (
		.clk(clk),
		.arst_n(arst_n),
		.chars(chars),
		.res_free(res_free),
		.default_port(default_port),
		.res_load(res_load),
		.res(res)
	);

	assign res_free = ~res_valid_q | verdict.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_free) begin
			res_valid_q <= res_load;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res;
		end
	end

	assign verdict.valid = res_valid_q;
	assign verdict.accepted = res_q.accepted;
	assign verdict.address_start = res_q.address_start;
	assign verdict.address_length = res_q.address_length;
	assign verdict.port_number = res_q.port_number;

	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_q.accepted |-> !res_q.address_start && res_q.address_length == '0)
		else $error("rejected verdict carries address data");

	a_hold_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !verdict.ready |=> res_valid_q && $stable(res_q))
		else $error("stalled verdict changed");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> res_free)
		else $error("verdict loaded over an untaken one");

endmodule

[src/hpp_cfg.sv]
module hpp_cfg (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [hpp_pkg::CFG_AW-1:0] paddr,
	input logic [hpp_pkg::CFG_DW-1:0] pwdata,
	output logic [hpp_pkg::CFG_DW-1:0] prdata,
	output logic pready,
	output logic [hpp_pkg::PORT_W-1:0] default_port
);

	logic [hpp_pkg::PORT_W-1:0] default_port_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_port_q <= '0;
		end else if (wr_en) begin
			default_port_q <= pwdata[hpp_pkg::PORT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr)
			hpp_pkg::REG_DEFAULT_PORT: prdata[hpp_pkg::PORT_W-1:0] = default_port_q;
			default: prdata = '0;
		endcase
	end

	assign default_port = default_port_q;

endmodule

[src/hpp_parse.sv]
module hpp_parse #(
	parameter int ADDR_CAP = hpp_pkg::ADDR_CAP_DEF
) (
	input logic clk,
	input logic arst_n,
	hpp_char_if.sink chars,
	input logic res_free,
	input logic [hpp_pkg::PORT_W-1:0] default_port,
	output logic res_load,
	output hpp_pkg::verdict_t res
);

	localparam int POS_W = $clog2(ADDR_CAP + 2);
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(ADDR_CAP + 1);
	localparam logic [POS_W-1:0] LEN_CAP = POS_W'(ADDR_CAP);

	logic s1_valid;
	logic [hpp_pkg::CHAR_W-1:0] char_s1;
	logic last_s1;
	logic go;

	logic [POS_W-1:0] position_q, position_d;
	logic bracketed_q, bracketed_d;
	logic close_seen_q, close_seen_d;
	logic [1:0] phase_q, phase_d;
	logic [1:0] colon_count_q, colon_count_d;
	logic [POS_W-1:0] addr_len_q, addr_len_d;
	logic [hpp_pkg::ACC_W-1:0] accum_q, accum_d;
	logic digit_q, digit_d;
	logic bad_q, bad_d;
	logic over_q, over_d;
	logic [2*hpp_pkg::CHAR_W-1:0] prev_q, prev_d;
	logic reject_q, reject_d;

	logic feed;
	logic is_digit;
	logic [hpp_pkg::PROD_W-1:0] prod;
	logic ok;
	logic port_ok;

	assign go = s1_valid & (~last_s1 | res_free);
	assign chars.ready = ~s1_valid | go;
	assign res_load = go & last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (chars.ready) begin
			s1_valid <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			char_s1 <= chars.character;
			last_s1 <= chars.last_char;
		end
	end

	assign is_digit = (char_s1 >= hpp_pkg::CH_ZERO) && (char_s1 <= hpp_pkg::CH_NINE);
	assign prod = hpp_pkg::PROD_W'(accum_q) * hpp_pkg::PROD_W'(10)
		+ hpp_pkg::PROD_W'(char_s1 - hpp_pkg::CH_ZERO);

	always_comb begin
		position_d = position_q;
		bracketed_d = bracketed_q;
		close_seen_d = close_seen_q;
		phase_d = phase_q;
		colon_count_d = colon_count_q;
		addr_len_d = addr_len_q;
		reject_d = reject_q;
		feed = 1'b0;

		if (position_q == '0 && hpp_pkg::is_space(char_s1)) begin
			reject_d = 1'b1;
		end

		if (position_q == '0 && char_s1 == hpp_pkg::CH_OPEN) begin
			bracketed_d = 1'b1;
		end else if (bracketed_q) begin
			if (!close_seen_q) begin
				if (char_s1 == hpp_pkg::CH_CLOSE) begin
					close_seen_d = 1'b1;
					addr_len_d = position_q - POS_W'(1);
				end
			end else if (phase_q == hpp_pkg::PH_NONE) begin
				phase_d = (char_s1 == hpp_pkg::CH_COLON) ? hpp_pkg::PH_COLON
					: hpp_pkg::PH_OTHER;
			end else if (phase_q == hpp_pkg::PH_COLON) begin
				feed = 1'b1;
			end
		end else begin
			if (colon_count_q == 2'd0) begin
				if (char_s1 == hpp_pkg::CH_COLON) begin
					colon_count_d = 2'd1;
					addr_len_d = position_q;
				end
			end else begin
				if (char_s1 == hpp_pkg::CH_COLON) begin
					colon_count_d = 2'd2;
				end
				feed = 1'b1;
			end
		end

		if (char_s1 == hpp_pkg::CH_SLASH && prev_q[7:0] == hpp_pkg::CH_SLASH
			&& prev_q[15:8] == hpp_pkg::CH_COLON) begin
			reject_d = 1'b1;
		end
		prev_d = {prev_q[7:0], char_s1};
		if (position_q < POS_MAX) begin
			position_d = position_q + POS_W'(1);
		end

		if (last_s1 && hpp_pkg::is_space(char_s1)) begin
			reject_d = 1'b1;
		end
	end

	always_comb begin
		accum_d = accum_q;
		digit_d = digit_q;
		bad_d = bad_q;
		over_d = over_q;
		if (feed) begin
			if (is_digit) begin
				digit_d = 1'b1;
				if (!over_q) begin
					if (prod > hpp_pkg::PROD_W'(hpp_pkg::PORT_LIMIT)) begin
						over_d = 1'b1;
						accum_d = hpp_pkg::PORT_LIMIT + hpp_pkg::ACC_W'(1);
					end else begin
						accum_d = prod[hpp_pkg::ACC_W-1:0];
					end
				end
			end else begin
				bad_d = 1'b1;
			end
		end
	end

	always_comb begin
		ok = ~reject_d && addr_len_d != '0 && addr_len_d < LEN_CAP;
		if (bracketed_d) begin
			ok = ok && close_seen_d && phase_d != hpp_pkg::PH_OTHER;
		end else begin
			ok = ok && colon_count_d == 2'd1;
		end
		port_ok = digit_d && !bad_d && !over_d && accum_d != '0
			&& accum_d <= hpp_pkg::PORT_LIMIT;

		res.accepted = ok;
		res.address_start = ok & bracketed_d;
		res.address_length = ok ? hpp_pkg::LEN_W'(addr_len_d) : '0;
		res.port_number = (ok && port_ok) ? accum_d[hpp_pkg::PORT_W-1:0] : default_port;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			bracketed_q <= 1'b0;
			close_seen_q <= 1'b0;
			phase_q <= hpp_pkg::PH_NONE;
			colon_count_q <= 2'd0;
			addr_len_q <= '0;
			accum_q <= '0;
			digit_q <= 1'b0;
			bad_q <= 1'b0;
			over_q <= 1'b0;
			prev_q <= '0;
			reject_q <= 1'b0;
		end else if (go) begin
			if (last_s1) begin
				position_q <= '0;
				bracketed_q <= 1'b0;
				close_seen_q <= 1'b0;
				phase_q <= hpp_pkg::PH_NONE;
				colon_count_q <= 2'd0;
				addr_len_q <= '0;
				accum_q <= '0;
				digit_q <= 1'b0;
				bad_q <= 1'b0;
				over_q <= 1'b0;
				prev_q <= '0;
				reject_q <= 1'b0;
			end else begin
				position_q <= position_d;
				bracketed_q <= bracketed_d;
				close_seen_q <= close_seen_d;
				phase_q <= phase_d;
				colon_count_q <= colon_count_d;
				addr_len_q <= addr_len_d;
				accum_q <= accum_d;
				digit_q <= digit_d;
				bad_q <= bad_d;
				over_q <= over_d;
				prev_q <= prev_d;
				reject_q <= reject_d;
			end
		end
	end

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		position_q <= POS_MAX)
		else $error("position ran past its saturation point");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> position_q == '0 && !reject_q && !bracketed_q)
		else $error("string state not cleared after the final word");

	a_over_sat: assert property (@(posedge clk) disable iff (!arst_n)
		over_q |-> accum_q == hpp_pkg::PORT_LIMIT + hpp_pkg::ACC_W'(1))
		else $error("port overflow without a saturated accumulator");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && !go |=> s1_valid && $stable(char_s1) && $stable(last_s1))
		else $error("stalled word lost from the input register");

endmodule

[tb/sv/tb_top.sv]
module tb_top;
	import hpp_pkg::*;

	localparam int ADDR_CAP = ADDR_CAP_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_WORDS = 84;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic fin;
	} char_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel;
	logic penable;
	logic pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [CFG_DW-1:0] pwdata;
	logic [CFG_DW-1:0] prdata;
	logic pready;

	hpp_char_if chars_if();
	hpp_verdict_if verdict_if();

	host_port_string_parser DUT (
		.clk(clk),
		.arst_n(arst_n),
		.chars(chars_if),
		.verdict(verdict_if),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #2 clk = ~clk;

	char_word_t word_q[$];
	char_word_t next_word;
	logic [CHAR_W-1:0] cur_str[$];
	verdict_t verdict_q[$];
	verdict_t want;
	int phase_words;
	int err_count = 0;
	int cycle_cnt = 0;
	int rx_hold;
	logic hold_req = 1'b0;
	logic calm = 1'b0;

	// Running parse state of the string in flight.
	logic [PORT_W-1:0] port_default = '0;
	int str_pos;
	logic in_brackets;
	logic close_hit;
	logic [1:0] tail_phase;
	int colon_cnt;
	int addr_len;
	int port_val;
	logic has_digit;
	logic has_bad;
	logic port_ovf;
	logic [15:0] prev_chars;
	logic rejected;

	task automatic clear_string();
		str_pos = 0;
		in_brackets = 1'b0;
		close_hit = 1'b0;
		tail_phase = PH_NONE;
		colon_cnt = 0;
		addr_len = 0;
		port_val = 0;
		has_digit = 1'b0;
		has_bad = 1'b0;
		port_ovf = 1'b0;
		prev_chars = '0;
		rejected = 1'b0;
	endtask

	task automatic port_char(input logic [CHAR_W-1:0] c);
		if (c >= CH_ZERO && c <= CH_NINE) begin
			has_digit = 1'b1;
			if (!port_ovf) begin
				port_val = port_val * 10 + int'(c - CH_ZERO);
				if (port_val > int'(PORT_LIMIT)) begin
					port_ovf = 1'b1;
					port_val = int'(PORT_LIMIT) + 1;
				end
			end
		end else begin
			has_bad = 1'b1;
		end
	endtask

	task automatic parse_byte(input logic [CHAR_W-1:0] c, input logic fin);
		verdict_t v;
		logic ok;
		logic blank;
		blank = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
		if (str_pos == 0 && blank)
			rejected = 1'b1;
		if (str_pos == 0 && c == CH_OPEN) begin
			in_brackets = 1'b1;
		end else if (in_brackets) begin
			if (!close_hit) begin
				if (c == CH_CLOSE) begin
					close_hit = 1'b1;
					addr_len = str_pos - 1;
				end
			end else if (tail_phase == PH_NONE) begin
				tail_phase = (c == CH_COLON) ? PH_COLON : PH_OTHER;
			end else if (tail_phase == PH_COLON) begin
				port_char(c);
			end
		end else if (colon_cnt == 0) begin
			if (c == CH_COLON) begin
				colon_cnt = 1;
				addr_len = str_pos;
			end
		end else begin
			if (c == CH_COLON)
				colon_cnt = 2;
			port_char(c);
		end
		if (c == CH_SLASH && prev_chars[7:0] == CH_SLASH && prev_chars[15:8] == CH_COLON)
			rejected = 1'b1;
		prev_chars = {prev_chars[7:0], c};
		if (str_pos < ADDR_CAP + 1)
			str_pos++;
		if (fin) begin
			if (blank)
				rejected = 1'b1;
			ok = !rejected && addr_len != 0 && addr_len < ADDR_CAP;
			if (in_brackets)
				ok = ok && close_hit && tail_phase != PH_OTHER;
			else
				ok = ok && colon_cnt == 1;
			v.accepted = ok;
			v.address_start = ok && in_brackets;
			v.address_length = ok ? addr_len[LEN_W-1:0] : '0;
			if (ok && has_digit && !has_bad && !port_ovf && port_val >= 1)
				v.port_number = port_val[PORT_W-1:0];
			else
				v.port_number = port_default;
			verdict_q.push_back(v);
			clear_string();
		end
	endtask

	task automatic report_mismatch(input string msg);
		err_count++;
		$display("verdict mismatch: %s", msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_if.valid <= 1'b0;
			chars_if.character <= '0;
			chars_if.last_char <= 1'b0;
			clear_string();
		end else begin
			if (chars_if.valid && chars_if.ready)
				parse_byte(chars_if.character, chars_if.last_char);
			if (!chars_if.valid || chars_if.ready) begin
				if (word_q.size() != 0 && (calm || $urandom_range(0, 99) >= 31)) begin
					next_word = word_q.pop_front();
					chars_if.valid <= 1'b1;
					chars_if.character <= next_word.ch;
					chars_if.last_char <= next_word.fin;
				end else begin
					chars_if.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdict_if.ready <= 1'b0;
		end else begin
			if (verdict_if.valid && verdict_if.ready) begin
				if (verdict_q.size() == 0) begin
					report_mismatch("verdict word with no string pending");
				end else begin
					want = verdict_q.pop_front();
					if (verdict_if.accepted !== want.accepted)
						report_mismatch($sformatf("accepted got %0b, expected %0b",
							verdict_if.accepted, want.accepted));
					if (verdict_if.address_start !== want.address_start)
						report_mismatch($sformatf("address_start got %0b, expected %0b",
							verdict_if.address_start, want.address_start));
					if (verdict_if.address_length !== want.address_length)
						report_mismatch($sformatf("address_length got %0d, expected %0d",
							verdict_if.address_length, want.address_length));
					if (verdict_if.port_number !== want.port_number)
						report_mismatch($sformatf("port_number got %0d, expected %0d",
							verdict_if.port_number, want.port_number));
				end
			end
			verdict_if.ready <= (rx_hold == 0) && (calm || $urandom_range(0, 99) >= 31);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_hold <= 0;
		end else if (rx_hold != 0) begin
			rx_hold <= rx_hold - 1;
		end else if (hold_req) begin
			rx_hold <= HOLD_CYCLES;
		end
	end

	always @(posedge clk) begin
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			cycle_cnt <= cycle_cnt + 1;
		end
	end

	task automatic apb_write(input logic [PORT_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_DEFAULT_PORT;
		pwdata <= CFG_DW'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		port_default = value;
	endtask

	task automatic settle();
		@(negedge clk);
		while (word_q.size() != 0 || chars_if.valid || verdict_q.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			cur_str.push_back(s[i]);
	endtask

	task automatic end_string();
		foreach (cur_str[i])
			word_q.push_back('{cur_str[i], i == cur_str.size() - 1});
		phase_words += cur_str.size();
		cur_str.delete();
	endtask

	function automatic logic [CHAR_W-1:0] space_byte();
		int w;
		w = $urandom_range(0, 5);
		return (w == 5) ? CH_SPACE : CH_TAB + CHAR_W'(w);
	endfunction

	function automatic logic [CHAR_W-1:0] addr_byte(input logic bracket_form);
		logic [CHAR_W-1:0] b;
		do begin
			if ($urandom_range(0, 1))
				b = 8'h61 + CHAR_W'($urandom_range(0, 25));
			else
				b = CHAR_W'($urandom_range(0, 255));
		end while ((!bracket_form && b == CH_COLON) || (bracket_form && b == CH_CLOSE));
		return b;
	endfunction

	function automatic logic [CHAR_W-1:0] noise_byte();
		case ($urandom_range(0, 7))
			0: return CH_COLON;
			1: return CH_SLASH;
			2: return CH_OPEN;
			3: return CH_CLOSE;
			4: return space_byte();
			5: return CH_ZERO + CHAR_W'($urandom_range(0, 9));
			6: return 8'h61;
			default: return CHAR_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic gen_port();
		int r;
		int n;
		int base;
		string s;
		r = $urandom_range(0, 99);
		if (r < 15)
			return;
		if (r < 80) begin
			case ($urandom_range(0, 6))
				0: n = 0;
				1: n = 1;
				2: n = 65535;
				3: n = 65536;
				4: n = $urandom_range(1, 65535);
				5: n = $urandom_range(0, 999);
				default: n = $urandom_range(65536, 999999);
			endcase
			s = $sformatf("%0d", n);
			if ($urandom_range(0, 4) == 0)
				s = {"0", s};
			base = cur_str.size();
			put_text(s);
			if (r >= 65)
				cur_str.insert($urandom_range(base, cur_str.size()),
					CHAR_W'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(1, 4))
				cur_str.push_back(noise_byte());
		end
	endtask

	task automatic gen_string();
		int k;
		int r;
		int len;
		k = $urandom_range(0, 99);
		r = $urandom_range(0, 99);
		if (r < 88)
			len = $urandom_range(1, 6);
		else if (r < 97)
			len = $urandom_range(7, 20);
		else
			len = ADDR_CAP - 2 + $urandom_range(0, 3);
		if ($urandom_range(0, 29) == 0)
			len = 0;
		if ($urandom_range(0, 19) == 0)
			cur_str.push_back(space_byte());
		if (k < 40) begin
			repeat (len) cur_str.push_back(addr_byte(1'b0));
			cur_str.push_back(CH_COLON);
			gen_port();
		end else if (k < 75) begin
			cur_str.push_back(CH_OPEN);
			repeat (len) cur_str.push_back(addr_byte(1'b1));
			r = $urandom_range(0, 99);
			if (r < 95) begin
				cur_str.push_back(CH_CLOSE);
				if (r >= 35 && r < 80) begin
					cur_str.push_back(CH_COLON);
					gen_port();
				end else if (r >= 80) begin
					cur_str.push_back(addr_byte(1'b0));
					repeat ($urandom_range(0, 2)) cur_str.push_back(noise_byte());
				end
			end
		end else begin
			repeat ($urandom_range(1, 8)) cur_str.push_back(noise_byte());
		end
		if ($urandom_range(0, 19) == 0)
			put_text("://");
		if ($urandom_range(0, 19) == 0)
			cur_str.push_back(space_byte());
		end_string();
	endtask

	initial begin
		logic [PORT_W-1:0] cfg_val;
		chars_if.valid = 1'b0;
		chars_if.character = '0;
		chars_if.last_char = 1'b0;
		verdict_if.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		apb_write(16'd8080);
		put_text("[b]"); end_string();
		put_text("[]"); end_string();
		put_text("[c]x"); end_string();
		put_text("a::"); end_string();
		cur_str.push_back(CH_TAB); put_text("a:"); end_string();
		put_text("a:"); cur_str.push_back(CH_CR); end_string();
		put_text("a://"); end_string();
		cur_str.push_back(8'h00); cur_str.push_back(CH_COLON);
		cur_str.push_back(8'hFF); end_string();
		put_text("x"); end_string();
		put_text("[d]:0"); end_string();
		put_text("h:65535"); end_string();
		settle();

		for (int p = 0; p < 5; p++) begin
			case (p)
				0: cfg_val = 16'hFFFF;
				1: cfg_val = 16'h0000;
				3: cfg_val = 16'h0001;
				default: cfg_val = PORT_W'($urandom_range(2, 65534));
			endcase
			apb_write(cfg_val);
			calm = (p == 2);
			phase_words = 0;
			while (phase_words < PHASE_WORDS)
				gen_string();
			// The sink holds off long enough for a final word to back up the input.
			if (p == 1) begin
				hold_req <= 1'b1;
				@(posedge clk);
				hold_req <= 1'b0;
			end
			settle();
		end

		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
